// ===== src/interval_map_table_top_defines.svh =====
// Shared assertion macros for the interval map table.
`ifndef INTERVAL_MAP_TABLE_TOP_DEFINES_SVH
`define INTERVAL_MAP_TABLE_TOP_DEFINES_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define IMT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define IMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/imt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package imt_pkg;
   localparam int CAPACITY_DEF   = 64;
   localparam int KEY_BITS_DEF   = 32;
   localparam int VALUE_BITS_DEF = 16;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic ACTION_LOOKUP = 1'b0;
   localparam logic ACTION_ASSIGN = 1'b1;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;       // capture request word, clear scan state
      logic scan_rd;    // issue read of entry scan index
      logic scan_eval;  // evaluate read data of previous read
      logic plan;       // compute new layout after scan
      logic move_rd;    // issue read for compaction move
      logic move_wr;    // write one entry of the compaction
      logic commit;     // update entry count, build response
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic is_assign;
      logic empty_range;
      logic skip;       // nothing to change
      logic full;
      logic scan_last;  // scan read index past the last entry or table empty
      logic move_done;
      logic move_write; // current move step writes
   } stat_type;
endpackage
`default_nettype wire

// ===== src/imt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module imt_datapath #(
   parameter int CAPACITY   = 64,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire imt_pkg::cmd_type      cmd,
   output imt_pkg::stat_type          stat,
   input  wire logic                  req_action,
   input  wire logic [KEY_BITS-1:0]   req_range_begin,
   input  wire logic [KEY_BITS-1:0]   req_range_end,
   input  wire logic [VALUE_BITS-1:0] req_new_value,
   input  wire logic [KEY_BITS-1:0]   req_query_key,
   input  wire logic [15:0]           dflt,
   output logic [15:0]                found_value,
   output logic [1:0]                 status
);
   import imt_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = CW + 1;

   logic [KEY_BITS-1:0]   keys_mem [CAPACITY];
   logic [VALUE_BITS-1:0] vals_mem [CAPACITY];

   logic [CW-1:0] count_ff, count_in;
   logic act_ff;
   logic [KEY_BITS-1:0] b_ff, e_ff, q_ff;
   logic [VALUE_BITS-1:0] v_ff;

   // Scan results.
   logic [CW-1:0] idx_ff;         // next entry to read
   logic [CW-1:0] ridx_ff;        // index of data in rk/rv
   logic [CW-1:0] n_lt_b_ff;      // entries with key < begin
   logic [CW-1:0] n_lt_e_ff;      // entries with key < end
   logic          end_hit_ff;
   logic          any_ff;
   logic [VALUE_BITS-1:0] below_ff; // value below end or at/below query
   logic [KEY_BITS-1:0]   rk_ff;
   logic [VALUE_BITS-1:0] rv_ff;

   // Plan results.
   logic [PW-1:0] new_count_ff;
   logic          full_ff, skip_ff;
   logic [CW-1:0] src_ff, dst_ff; // tail move source and destination
   logic          shift_up_ff;    // tail moves toward higher indexes
   logic [CW-1:0] moves_left_ff;
   logic          move_wr_pend_ff;
   logic [CW-1:0] mv_dst_ff;
   logic          ins_phase_ff;   // writing begin / end points

   logic [15:0] fv_ff;
   logic [1:0]  st_ff;

   // Memory read port.
   logic [IW-1:0] rd_addr;
   always_comb begin
      rd_addr = idx_ff[IW-1:0];
      if (cmd.move_rd) rd_addr = src_ff[IW-1:0];
   end
   always_ff @(posedge clock) begin
      if (cmd.scan_rd || cmd.move_rd) begin
         rk_ff <= keys_mem[rd_addr];
         rv_ff <= vals_mem[rd_addr];
      end
   end

   logic [KEY_BITS-1:0] lim;
   logic lim_lt, key_lt_b;
   always_comb begin
      lim      = act_ff ? e_ff : q_ff;
      lim_lt   = act_ff ? (rk_ff < e_ff) : (rk_ff <= q_ff);
      key_lt_b = rk_ff < b_ff;
   end

   // Plan arithmetic.
   logic [PW-1:0] tail_cnt, nc;
   logic [PW-1:0] dst_start;
   always_comb begin
      tail_cnt  = PW'(count_ff) - PW'(n_lt_e_ff);
      dst_start = PW'(n_lt_b_ff) + (end_hit_ff ? PW'(1) : PW'(2));
      nc        = dst_start + tail_cnt;
   end

   logic [KEY_BITS-1:0]   wr_key;
   logic [VALUE_BITS-1:0] wr_val;
   logic [IW-1:0]         wr_addr;
   logic                  wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      if (wr_en) begin
         keys_mem[wr_addr] <= wr_key;
         vals_mem[wr_addr] <= wr_val;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.commit && act_ff && !(b_ff >= e_ff) && !skip_ff && !full_ff)
         count_in = new_count_ff[CW-1:0];
   end

   // Write path: tail moves, then end point (if not already present), then begin point.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = mv_dst_ff[IW-1:0];
      wr_key  = rk_ff;
      wr_val  = rv_ff;
      if (cmd.move_wr) begin
         if (!ins_phase_ff) begin
            wr_en = move_wr_pend_ff;
         end else begin
            wr_en = 1'b1;
            if (moves_left_ff == CW'(1)) begin
               wr_addr = n_lt_b_ff[IW-1:0];
               wr_key  = b_ff;
               wr_val  = v_ff;
            end else begin
               wr_addr = IW'(n_lt_b_ff + CW'(1));
               wr_key  = e_ff;
               wr_val  = below_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff     <= req_action;
         b_ff       <= req_range_begin;
         e_ff       <= req_range_end;
         v_ff       <= req_new_value;
         q_ff       <= req_query_key;
         idx_ff     <= '0;
         n_lt_b_ff  <= '0;
         n_lt_e_ff  <= '0;
         end_hit_ff <= 1'b0;
         any_ff     <= 1'b0;
         below_ff   <= VALUE_BITS'(dflt);
      end
      if (cmd.scan_rd) begin
         ridx_ff <= idx_ff;
         idx_ff  <= idx_ff + CW'(1);
      end
      if (cmd.scan_eval) begin
         if (lim_lt) begin
            below_ff  <= rv_ff;
            any_ff    <= 1'b1;
            n_lt_e_ff <= ridx_ff + CW'(1);
         end
         if (key_lt_b) n_lt_b_ff <= ridx_ff + CW'(1);
         if (rk_ff == lim) end_hit_ff <= 1'b1;
      end
      if (cmd.plan) begin
         new_count_ff  <= nc;
         full_ff       <= nc > PW'(CAPACITY);
         skip_ff       <= !any_ff && (v_ff == VALUE_BITS'(dflt));
         shift_up_ff   <= dst_start > PW'(n_lt_e_ff);
         ins_phase_ff  <= 1'b0;
         move_wr_pend_ff <= 1'b0;
         moves_left_ff <= tail_cnt[CW-1:0];
         if (dst_start > PW'(n_lt_e_ff)) begin
            src_ff <= CW'(PW'(count_ff) - PW'(1));
            dst_ff <= CW'(nc - PW'(1));
         end else begin
            src_ff <= n_lt_e_ff;
            dst_ff <= dst_start[CW-1:0];
         end
      end
      if (cmd.move_rd) begin
         mv_dst_ff       <= dst_ff;
         move_wr_pend_ff <= 1'b1;
         moves_left_ff   <= moves_left_ff - CW'(1);
         src_ff <= shift_up_ff ? src_ff - CW'(1) : src_ff + CW'(1);
         dst_ff <= shift_up_ff ? dst_ff - CW'(1) : dst_ff + CW'(1);
      end
      if (cmd.move_wr) begin
         move_wr_pend_ff <= 1'b0;
         if (ins_phase_ff) begin
            moves_left_ff <= moves_left_ff - CW'(1);
         end else if (moves_left_ff == '0) begin
            ins_phase_ff  <= 1'b1;
            moves_left_ff <= end_hit_ff ? CW'(1) : CW'(2);
         end
      end
      if (cmd.commit) begin
         fv_ff <= '0;
         st_ff <= STATUS_DONE;
         if (!act_ff) fv_ff <= 16'(below_ff);
         else if (b_ff >= e_ff) st_ff <= STATUS_EMPTY;
         else if (!skip_ff && full_ff) st_ff <= STATUS_FULL;
      end
   end

   always_comb begin
      stat.is_assign   = act_ff;
      stat.empty_range = b_ff >= e_ff;
      stat.skip        = skip_ff;
      stat.full        = full_ff;
      stat.scan_last   = (idx_ff >= count_ff);
      stat.move_done   = ins_phase_ff && (moves_left_ff == '0);
      stat.move_write  = move_wr_pend_ff || ins_phase_ff ||
                         (moves_left_ff == '0);
      found_value      = fv_ff;
      status           = st_ff;
   end
endmodule
`default_nettype wire

// ===== src/imt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module imt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output imt_pkg::cmd_type       cmd,
   input  wire imt_pkg::stat_type stat
);
   import imt_pkg::*;
   `include "interval_map_table_top_defines.svh"

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_EVAL = 3'd2;
   localparam logic [2:0] S_PLAN = 3'd3;
   localparam logic [2:0] S_DEC  = 3'd4;
   localparam logic [2:0] S_MOVE = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = (state_ff == S_IDLE) && !rsp_valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // read each entry in turn, evaluating it before the next read; stop at the end of the table
            if (stat.scan_last) begin
               state_in = S_PLAN;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.scan_eval = 1'b1;
            state_in      = S_SCAN;
         end
         S_PLAN: begin
            cmd.plan = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            if (!stat.is_assign || stat.empty_range || stat.skip || stat.full)
               state_in = S_DONE;
            else
               state_in = S_MOVE;
         end
         S_MOVE: begin
            // alternate read and write of each shifted entry
            if (stat.move_done) begin
               state_in = S_DONE;
            end else if (stat.move_write) begin
               cmd.move_wr = 1'b1;
            end else begin
               cmd.move_rd = 1'b1;
            end
         end
         S_DONE: begin
            cmd.commit   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `IMT_ASSERT_NEXT(a_done_valid, clock, reset, state_ff == S_DONE, rsp_valid_ff, "no rsp")
   `IMT_ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, state_ff == S_IDLE, "ready busy")
   `IMT_ASSERT_IMPL(a_one_cmd, clock, reset, 1'b1, $onehot0(cmd), "cmd overlap")
endmodule
`default_nettype wire

// ===== src/interval_map_table_top.sv =====
// Interval map table: sorted breakpoint table in a single-port memory.
// An operation scans all N stored entries, then plans; an assign that changes the table
// then reads and writes each moved entry and writes one or two insert points.
// Throughput: one word at a time; next request taken once the response left.
// Reset (synchronous, active high) empties the table and clears default.
`timescale 1ns / 1ps
`default_nettype none
module interval_map_table_top #(
   parameter int CAPACITY   = imt_pkg::CAPACITY_DEF,
   parameter int KEY_BITS   = imt_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = imt_pkg::VALUE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_action,
   input  wire logic [KEY_BITS-1:0]   req_range_begin,
   input  wire logic [KEY_BITS-1:0]   req_range_end,
   input  wire logic [VALUE_BITS-1:0] req_new_value,
   input  wire logic [KEY_BITS-1:0]   req_query_key,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [15:0]                rsp_found_value,
   output logic [1:0]                 rsp_status,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [15:0]           csr_data
);
   import imt_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic [15:0] dflt_ff;

   // Hold default value; it must be written only while idle, which the block does not enforce.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) dflt_ff <= '0;
      else if (csr_valid) dflt_ff <= csr_data;
   end

   imt_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cmd, .stat
   );

   imt_datapath #(
      .CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
   ) u_dp (
      .clock, .reset, .cmd, .stat, .req_action, .req_range_begin,
      .req_range_end, .req_new_value, .req_query_key, .dflt(dflt_ff),
      .found_value(rsp_found_value), .status(rsp_status)
   );
endmodule
`default_nettype wire

// ===== verif/interval_map_table_top_test.sv =====
`timescale 1ns / 1ps

// Scoreboard for the interval map: keeps its own breakpoint table, predicts
// the response to each accepted request word and checks responses in order.
class interval_map_scoreboard;
   typedef struct {
      bit [15:0] found_value;
      bit [1:0]  status;
   } rsp_word_type;

   bit [31:0] bp_keys[$];
   bit [15:0] bp_values[$];
   bit [15:0] default_value;
   rsp_word_type expected_rsps[$];
   int        mismatches;
   int        rsp_count;
   int        full_count;
   int        empty_count;

   function void set_default(bit [15:0] value);
      default_value = value;
   endfunction

   function bit [15:0] map_at(bit [31:0] key);
      bit [15:0] v;
      v = default_value;
      foreach (bp_keys[i]) begin
         if (bp_keys[i] <= key) v = bp_values[i];
         else break;
      end
      return v;
   endfunction

   function bit [1:0] assign_range(bit [31:0] first, bit [31:0] last_excl, bit [15:0] value);
      bit [31:0] new_keys[$];
      bit [15:0] new_values[$];
      bit [15:0] before_end;
      bit        any_below;
      bit        end_present;
      if (!(first < last_excl)) return imt_pkg::STATUS_EMPTY;
      before_end = default_value;
      any_below = 0;
      end_present = 0;
      foreach (bp_keys[i]) begin
         if (bp_keys[i] < last_excl) begin
            before_end = bp_values[i];
            any_below = 1;
         end
         if (bp_keys[i] == last_excl) end_present = 1;
      end
      // a default write over a clear prefix changes nothing
      if (!any_below && value == default_value) return imt_pkg::STATUS_DONE;
      foreach (bp_keys[i]) begin
         if (bp_keys[i] < first) begin
            new_keys.push_back(bp_keys[i]);
            new_values.push_back(bp_values[i]);
         end
      end
      new_keys.push_back(first);
      new_values.push_back(value);
      if (!end_present) begin
         new_keys.push_back(last_excl);
         new_values.push_back(before_end);
      end
      foreach (bp_keys[i]) begin
         if (bp_keys[i] >= last_excl) begin
            new_keys.push_back(bp_keys[i]);
            new_values.push_back(bp_values[i]);
         end
      end
      if (new_keys.size() > imt_pkg::CAPACITY_DEF) return imt_pkg::STATUS_FULL;
      bp_keys = new_keys;
      bp_values = new_values;
      return imt_pkg::STATUS_DONE;
   endfunction

   function void note_request(bit action, bit [31:0] first, bit [31:0] last_excl,
                              bit [15:0] value, bit [31:0] key);
      rsp_word_type w;
      w.found_value = 0;
      w.status = imt_pkg::STATUS_DONE;
      if (action == imt_pkg::ACTION_ASSIGN) begin
         w.status = assign_range(first, last_excl, value);
         if (w.status == imt_pkg::STATUS_FULL) full_count++;
         if (w.status == imt_pkg::STATUS_EMPTY) empty_count++;
      end else begin
         w.found_value = map_at(key);
      end
      expected_rsps.push_back(w);
   endfunction

   function void check_response(bit [15:0] found_value, bit [1:0] status);
      rsp_word_type w;
      rsp_count++;
      if (expected_rsps.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response found=%h status=%0d", found_value, status);
         return;
      end
      w = expected_rsps.pop_front();
      if (w.found_value != found_value || w.status != status) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response %0d: expected found=%h status=%0d, got found=%h status=%0d",
                     rsp_count, w.found_value, w.status, found_value, status);
      end
   endfunction

   function int pending();
      return expected_rsps.size();
   endfunction
endclass

module interval_map_table_top_test;
   import imt_pkg::*;

   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int DRAIN_CYCLES = 400;   // beyond the worst scan plus compaction

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_action = 0;
   logic [31:0] req_range_begin = 0;
   logic [31:0] req_range_end = 0;
   logic [15:0] req_new_value = 0;
   logic [31:0] req_query_key = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [15:0] rsp_found_value;
   logic [1:0]  rsp_status;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [15:0] csr_data = 0;

   interval_map_scoreboard sb = new();

   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   int  cycle_count = 0;
   int  req_count = 0;
   int  hold_len = 0;
   bit  hold_go = 0;
   bit  hold_seen = 0;
   int  hold_left = 0;

   interval_map_table_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_range_begin(req_range_begin), .req_range_end(req_range_end),
      .req_new_value(req_new_value), .req_query_key(req_query_key),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_found_value(rsp_found_value), .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // Cycle counter doubles as the run watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAIL interval_map_table_top");
         $finish;
      end
   end

   // Long receiver hold-off: a toggle of hold_go starts a hold-off counted down from hold_len.
   always @(posedge clock) begin
      if (hold_go != hold_seen) begin
         hold_seen <= hold_go;
         hold_left <= hold_len;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Drive rsp_ready with random stalls, dropping it during a hold-off.
   always @(posedge clock) begin
      rsp_ready <= (hold_left == 0) && (hold_go == hold_seen) &&
                   ($urandom_range(99) >= rsp_stall_pct);
   end

   // Check every accepted response word against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_found_value, rsp_status);
   end

   // Offer one request word and hold it until accepted; the predictor sees it
   // at the accepting edge.
   task automatic send_req(bit action, bit [31:0] first, bit [31:0] last_excl,
                           bit [15:0] value, bit [31:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_action <= action;
      req_range_begin <= first;
      req_range_end <= last_excl;
      req_new_value <= value;
      req_query_key <= key;
      do @(posedge clock); while (!req_ready);
      sb.note_request(action, first, last_excl, value, key);
      req_count++;
   endtask

   // Drop valid and wait for every outstanding response, then let the block settle.
   task automatic drain();
      req_valid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the default value register; callers drain first so the block is idle.
   task automatic write_default(bit [15:0] value);
      csr_valid <= 1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_default(value);
      csr_valid <= 0;
      csr_data <= 16'($urandom());
      @(posedge clock);
   endtask

   function automatic bit [31:0] pick_key();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) return $urandom_range(300);
      if (sel < 75) return 32'h0;
      if (sel < 80) return 32'hFFFF_FFFF;
      if (sel < 83) return 32'hFFFF_FFFE;
      return $urandom();
   endfunction

   function automatic bit [15:0] pick_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 40) return 16'($urandom_range(3));
      if (sel < 50) return sb.default_value;
      if (sel < 55) return 16'hFFFF;
      return 16'($urandom());
   endfunction

   // Mostly well-formed assigns over small keys so the table grows deep,
   // lookups into the populated span, some empty ranges and an occasional wipe.
   task automatic random_items(int n);
      bit [31:0] a;
      bit [31:0] b;
      int sel;
      repeat (n) begin
         sel = $urandom_range(99);
         a = pick_key();
         b = pick_key();
         if (sel < 2) begin
            send_req(ACTION_ASSIGN, 0, 32'hFFFF_FFFF, pick_value(), $urandom());
         end else if (sel < 40) begin
            if (a > b && $urandom_range(9) != 0) send_req(ACTION_ASSIGN, b, a, pick_value(),
                                                          $urandom());
            else send_req(ACTION_ASSIGN, a, b, pick_value(), $urandom());
         end else begin
            send_req(ACTION_LOOKUP, $urandom(), $urandom(), 16'($urandom()), a);
         end
      end
   endtask

   initial begin
      int i;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty table, both register extremes, the special cases.
      send_req(ACTION_LOOKUP, 0, 0, 0, 32'h0);
      send_req(ACTION_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_req(ACTION_ASSIGN, 100, 200, 16'h0000, 32'hFFFF_FFFF);  // default over clear prefix
      send_req(ACTION_ASSIGN, 50, 50, 16'h1234, 0);                // empty range
      send_req(ACTION_ASSIGN, 32'hFFFF_FFFF, 0, 16'h1234, 0);      // inverted range
      send_req(ACTION_ASSIGN, 100, 200, 16'hFFFF, 0);
      send_req(ACTION_ASSIGN, 150, 200, 16'hFFFF, 0);              // redundant neighbor
      send_req(ACTION_LOOKUP, 0, 0, 0, 99);
      send_req(ACTION_LOOKUP, 0, 0, 0, 100);
      send_req(ACTION_LOOKUP, 0, 0, 0, 199);
      send_req(ACTION_LOOKUP, 0, 0, 0, 200);
      send_req(ACTION_ASSIGN, 0, 32'hFFFF_FFFF, 16'hA5A5, 0);
      send_req(ACTION_ASSIGN, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 16'h5A5A, 0);
      send_req(ACTION_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF);
      send_req(ACTION_LOOKUP, 0, 0, 0, 32'hFFFF_FFFE);
      drain();
      write_default(16'hFFFF);
      send_req(ACTION_ASSIGN, 0, 32'hFFFF_FFFF, 16'hFFFF, 0);
      send_req(ACTION_LOOKUP, 0, 0, 0, 32'h8000_0000);
      drain();
      write_default(16'h0000);

      // Fill the table with disjoint islands until an assign overflows.
      for (i = 0; i < 34; i++) send_req(ACTION_ASSIGN, 10 + 4 * i, 11 + 4 * i, 16'(i + 1), 0);
      for (i = 0; i < 6; i++) send_req(ACTION_LOOKUP, 0, 0, 0, 8 + 2 * i);
      drain();

      // Phase: no idling.
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      random_items(300);
      drain();
      write_default(16'($urandom()));

      // Phase: sender mostly idle; pause for the pipe to empty midway.
      send_idle_pct = 76;
      rsp_stall_pct = 0;
      random_items(150);
      req_valid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      random_items(150);
      drain();
      write_default(16'h0001);

      // Phase: receiver mostly stalling, with one long hold-off to back up the input.
      send_idle_pct = 0;
      rsp_stall_pct = 76;
      hold_len <= 2000;
      hold_go <= ~hold_go;
      random_items(300);
      drain();
      write_default(16'h8000);

      // Phase: both sides idling now and then.
      send_idle_pct = 26;
      rsp_stall_pct = 26;
      random_items(300);
      drain();

      $display("covered %0d requests: %0d responses, %0d overflows, %0d empty ranges",
               req_count, sb.rsp_count, sb.full_count, sb.empty_count);
      $display("four idle/stall mixes, a long receiver hold-off, five default settings");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS interval_map_table_top");
      end else begin
         $display("FAIL interval_map_table_top");
      end
      $finish;
   end
endmodule
